>>> hw/rtl/bmsd_pkg.sv
`timescale 1ns / 1ps
package bmsd_pkg;
    localparam int RecBytes = 40;
    localparam logic [2:0] KIND_VERT  = 3'd0;
    localparam logic [2:0] KIND_FACE  = 3'd1;
    localparam logic [2:0] KIND_LOD   = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;
    localparam logic [2:0] KIND_ERR   = 3'd5;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_VERT   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_FACE   = 3'd3;
    localparam logic [2:0] PH_LOD    = 3'd4;
    localparam logic [2:0] PH_DRAIN  = 3'd5;

    localparam logic [31:0] FLT_POS_MAX = 32'h7F7FFFFF;
    localparam logic [31:0] FLT_NEG_MAX = 32'hFF7FFFFF;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
        logic [31:0] word4;
        logic [31:0] word5;
        logic [31:0] word6;
        logic [31:0] word7;
        logic [23:0] tangent_packed;
        logic [31:0] color_rgba;
        logic        last_record;
    } t_rec;

    function automatic logic [15:0] size_word(input logic [1:0] m);
        case (m)
            2'd0: size_word = 16'd12;
            2'd1: size_word = 16'd16;
            2'd2: size_word = 16'd24;
            default: size_word = 16'd32;
        endcase
    endfunction

    function automatic logic [5:0] header_len(input logic [1:0] m);
        case (m)
            2'd0: header_len = 6'd12;
            2'd1: header_len = 6'd16;
            2'd2: header_len = 6'd26;
            default: header_len = 6'd34;
        endcase
    endfunction

    function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        logic        nan;
        nan = (a[30:0] > 31'h7F800000) || (b[30:0] > 31'h7F800000);
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        if (nan || (a[30:0] == 31'd0 && b[30:0] == 31'd0)) begin
            flt_less = 1'b0;
        end else begin
            flt_less = ka < kb;
        end
    endfunction
endpackage

>>> hw/rtl/bmsd_in_if.sv
`timescale 1ns / 1ps
interface bmsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

>>> hw/rtl/bmsd_out_if.sv
`timescale 1ns / 1ps
interface bmsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;
    logic [31:0] word6;
    logic [31:0] word7;
    logic [23:0] tangent_packed;
    logic [31:0] color_rgba;
    logic        last_record;
    modport source (output valid, record_kind, word0, word1, word2, word3, word4, word5,
                    word6, word7, tangent_packed, color_rgba, last_record, input ready);
    modport sink (input valid, record_kind, word0, word1, word2, word3, word4, word5,
                  word6, word7, tangent_packed, color_rgba, last_record, output ready);
endinterface

>>> hw/rtl/bmsd_front.sv
`timescale 1ns / 1ps
// byte parser: assembles records, emits up to two records per word
module bmsd_front import bmsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output logic       o_push2,
    output t_rec       o_rec0,
    output t_rec       o_rec1
);
    logic [2:0]  r_phase;
    logic [5:0]  r_idx;
    logic [7:0]  r_buf [RecBytes];
    logic [31:0] r_vtot, r_ftot, r_done, r_second;
    logic [15:0] r_ltot, r_lseen;
    logic [35:0] r_skip;
    logic        r_color;
    logic [31:0] r_lo [3];
    logic [31:0] r_hi [3];

    logic [7:0]  b [RecBytes];
    logic [5:0]  idx1;
    logic [31:0] w [8];
    logic [31:0] hv, hf;
    logic [15:0] hl, hb;
    logic        hc;
    logic [35:0] hs;
    logic [2:0]  n_phase;
    logic [5:0]  n_idx;
    logic [31:0] n_vtot, n_ftot, n_done, n_second;
    logic [15:0] n_ltot, n_lseen;
    logic [35:0] n_skip;
    logic        n_color, fin, err, rec, restart;
    logic [31:0] n_lo [3];
    logic [31:0] n_hi [3];
    t_rec        r0, fr;
    logic [31:0] fc;

    always_comb begin
        for (int i = 0; i < RecBytes; i++) begin
            b[i] = (r_idx == 6'(i)) ? i_data_byte : r_buf[i];
        end
        for (int i = 0; i < 8; i++) begin
            w[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
        end
    end

    // header decode per mode
    always_comb begin
        hc = 1'b1;
        hl = 16'd0;
        hs = 36'd0;
        hb = {b[15], b[14]};
        case (i_mode)
            2'd0: begin
                hc = b[2] == 8'd40;
                hv = w[1];
                hf = w[2];
            end
            2'd1: begin
                hl = {b[7], b[6]};
                hv = w[2];
                hf = w[3];
            end
            default: begin
                hv = w[1];
                hf = w[2];
                hl = {b[13], b[12]};
                hs = (hb != 16'd0) ? {1'b0, w[1], 3'b000} : 36'd0;
            end
        endcase
    end

    always_comb begin
        idx1 = r_idx + 6'd1;
        n_phase = r_phase; n_idx = r_idx;
        n_vtot = r_vtot; n_ftot = r_ftot; n_ltot = r_ltot; n_done = r_done;
        n_skip = r_skip; n_color = r_color; n_second = r_second; n_lseen = r_lseen;
        n_lo = r_lo; n_hi = r_hi;
        fin = 1'b0; err = 1'b0; rec = 1'b0; restart = 1'b0;
        r0 = '0;
        if (r_phase == PH_DRAIN) begin
            restart = i_last_byte;
        end else begin
            if (r_phase == PH_SKIP) begin
                n_skip = r_skip - 36'd1;
                if (n_skip == 36'd0) begin
                    n_done = '0; n_idx = '0;
                    n_phase = (r_ftot != 0) ? PH_FACE : (r_ltot != 0) ? PH_LOD : PH_DRAIN;
                    fin = (r_ftot == 0) && (r_ltot == 0);
                end
            end else begin
                n_idx = idx1;
                case (r_phase)
                    PH_HEADER: begin
                        if (idx1 == 6'd2 && {b[1], b[0]} != size_word(i_mode)) begin
                            err = 1'b1;
                        end else if (idx1 >= header_len(i_mode)) begin
                            n_color = hc; n_vtot = hv; n_ftot = hf; n_ltot = hl;
                            n_skip = hs; n_done = '0; n_idx = '0;
                            if (hv != 0) n_phase = PH_VERT;
                            else if (hs != 0) n_phase = PH_SKIP;
                            else if (hf != 0) n_phase = PH_FACE;
                            else if (hl != 0) n_phase = PH_LOD;
                            else fin = 1'b1;
                        end
                    end
                    PH_VERT: begin
                        if (idx1 >= ((i_mode == 2'd0 && !r_color) ? 6'd36 : 6'd40)) begin
                            rec = 1'b1;
                            r0.record_kind = KIND_VERT;
                            r0.word0 = w[0]; r0.word1 = w[1]; r0.word2 = w[2];
                            r0.word3 = w[3]; r0.word4 = w[4]; r0.word5 = w[5];
                            r0.word6 = w[6]; r0.word7 = w[7];
                            r0.tangent_packed = {b[34], b[33], b[32]};
                            r0.color_rgba = r_color ? {b[39], b[38], b[37], b[36]}
                                                    : 32'hFFFFFFFF;
                            for (int i = 0; i < 3; i++) begin
                                if (flt_less(w[i], r_lo[i])) n_lo[i] = w[i];
                                if (flt_less(r_hi[i], w[i])) n_hi[i] = w[i];
                            end
                            n_idx = '0;
                            n_done = r_done + 32'd1;
                            if (n_done == r_vtot) begin
                                n_done = '0;
                                if (r_skip != 0) n_phase = PH_SKIP;
                                else if (r_ftot != 0) n_phase = PH_FACE;
                                else if (r_ltot != 0) n_phase = PH_LOD;
                                else fin = 1'b1;
                            end
                        end
                    end
                    PH_FACE: begin
                        if (idx1 >= 6'd12) begin
                            rec = 1'b1;
                            r0.record_kind = KIND_FACE;
                            r0.word0 = w[0]; r0.word1 = w[1]; r0.word2 = w[2];
                            n_idx = '0;
                            n_done = r_done + 32'd1;
                            if (n_done == r_ftot) begin
                                n_done = '0;
                                if (r_ltot != 0) n_phase = PH_LOD;
                                else fin = 1'b1;
                            end
                        end
                    end
                    PH_LOD: begin
                        if (idx1 >= 6'd4) begin
                            rec = 1'b1;
                            r0.record_kind = KIND_LOD;
                            r0.word0 = w[0];
                            if (r_lseen == 16'd1) n_second = w[0];
                            n_lseen = r_lseen + 16'd1;
                            n_idx = '0;
                            n_done = r_done + 32'd1;
                            if (n_done[15:0] == r_ltot && n_done[31:16] == 16'd0) fin = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (fin || err) begin
                restart = i_last_byte;
                n_phase = PH_DRAIN;
            end else if (i_last_byte) begin
                restart = 1'b1;
                // body cut short: judged on the section the byte leaves us in
                case (n_phase)
                    PH_HEADER: begin
                        fin = i_mode[1] && ({10'd0, idx1} >= size_word(i_mode))
                              && hv == 0 && hf == 0;
                        if (fin) begin n_vtot = hv; n_ftot = hf; end
                    end
                    PH_SKIP: fin = (n_ftot == 32'd0);
                    PH_LOD:  fin = 1'b1;
                    default: fin = 1'b0;
                endcase
                err = !fin;
            end
        end
    end

    always_comb begin
        fr = '0;
        fr.last_record = 1'b1;
        fc = (n_lseen > 16'd1 && n_second < n_ftot) ? n_second : n_ftot;
        if (err) begin
            fr.record_kind = KIND_ERR;
        end else if (n_vtot != 0) begin
            fr.record_kind = KIND_DONE;
            fr.word0 = fc;
            fr.word1 = n_lo[0]; fr.word2 = n_lo[1]; fr.word3 = n_lo[2];
            fr.word4 = n_hi[0]; fr.word5 = n_hi[1]; fr.word6 = n_hi[2];
            fr.word7 = n_vtot;
        end else begin
            fr.record_kind = KIND_EMPTY;
            fr.word0 = fc;
        end
    end

    wire fire = i_valid;
    wire endw = fin || err;
    assign o_push  = fire && (rec || endw);
    assign o_push2 = fire && rec && endw;
    assign o_rec0  = rec ? r0 : fr;
    assign o_rec1  = fr;

    always_ff @(posedge i_clk) begin
        if (fire && r_phase != PH_DRAIN && r_phase != PH_SKIP && r_idx < 6'(RecBytes)) begin
            r_buf[r_idx[5:0]] <= i_data_byte;
        end
        if (!i_rst_n || (fire && restart)) begin
            r_phase <= PH_HEADER; r_idx <= '0;
            r_vtot <= '0; r_ftot <= '0; r_ltot <= '0; r_done <= '0;
            r_skip <= '0; r_color <= 1'b0; r_second <= '0; r_lseen <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= FLT_POS_MAX;
                r_hi[i] <= FLT_NEG_MAX;
            end
        end else if (fire) begin
            r_phase <= n_phase; r_idx <= n_idx;
            r_vtot <= n_vtot; r_ftot <= n_ftot; r_ltot <= n_ltot; r_done <= n_done;
            r_skip <= n_skip; r_color <= n_color; r_second <= n_second;
            r_lseen <= n_lseen; r_lo <= n_lo; r_hi <= n_hi;
        end
    end
endmodule

>>> hw/rtl/bmsd_queue.sv
`timescale 1ns / 1ps
// record queue, up to two writes and one read per cycle
module bmsd_queue import bmsd_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_push2,
    input  t_rec i_rec0,
    input  t_rec i_rec1,
    output logic o_room,
    output logic o_valid,
    output t_rec o_rec,
    input  logic i_pop
);
    localparam int Aw = $clog2(Depth);
    t_rec r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic [Aw:0]   n_cnt;
    logic          pop;

    assign o_valid = r_cnt != '0;
    assign o_rec   = r_mem[r_rp];
    assign pop     = i_pop && o_valid;
    // room for two more words after anything this cycle
    assign o_room  = r_cnt <= (Aw+1)'(Depth - 2);

    always_comb begin
        n_cnt = r_cnt + (Aw+1)'(i_push) + (Aw+1)'(i_push2) - (Aw+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec0;
        if (i_push2) r_mem[r_wp + Aw'(1)] <= i_rec1;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + Aw'(i_push) + Aw'(i_push2);
            r_rp <= r_rp + Aw'(pop);
            r_cnt <= n_cnt;
        end
    end
endmodule

>>> hw/rtl/binary_mesh_stream_decoder.sv
`timescale 1ns / 1ps
// channel   | dir | payload
// s_in      | in  | data_byte, last_byte
// m_out     | out | record_kind, word0..word7, tangent_packed, color_rgba, last_record
// cfg       | in  | i_cfg_we / i_cfg_wdata (format_mode)
//
// one byte word accepted per cycle while the queue has room; a record is queued with its last byte
// the parser stalls only when the record queue has under two free slots
// a byte may yield two records (last data record plus done, empty or error), both queued at once
// reset synchronous active low; clears parser state, queue and format_mode
module binary_mesh_stream_decoder import bmsd_pkg::*; #(
    parameter int QDepth = QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    bmsd_in_if.sink    s_in,
    bmsd_out_if.source m_out
);
    logic [1:0] r_mode;
    logic       room, push, push2, qv;
    t_rec       rec0, rec1, head;

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // front parser sees a word only when the queue can take its records
    assign s_in.ready = room;

    bmsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mode(r_mode),
        .i_valid(s_in.valid && room), .i_data_byte(s_in.data_byte),
        .i_last_byte(s_in.last_byte),
        .o_push(push), .o_push2(push2), .o_rec0(rec0), .o_rec1(rec1)
    );

    // back: queue head drives the output directly
    bmsd_queue #(.Depth(QDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_push2(push2), .i_rec0(rec0), .i_rec1(rec1),
        .o_room(room), .o_valid(qv), .o_rec(head), .i_pop(m_out.ready)
    );

    assign m_out.valid          = qv;
    assign m_out.record_kind    = head.record_kind;
    assign m_out.word0          = head.word0;
    assign m_out.word1          = head.word1;
    assign m_out.word2          = head.word2;
    assign m_out.word3          = head.word3;
    assign m_out.word4          = head.word4;
    assign m_out.word5          = head.word5;
    assign m_out.word6          = head.word6;
    assign m_out.word7          = head.word7;
    assign m_out.tangent_packed = head.tangent_packed;
    assign m_out.color_rgba     = head.color_rgba;
    assign m_out.last_record    = head.last_record;
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import bmsd_pkg::*;

    localparam logic [2:0] PH_FIN = 3'd6;
    localparam logic [2:0] PH_ERR = 3'd7;
    localparam int CycleLimit = 400000;
    localparam int ByteTarget = 1950;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    bmsd_in_if  in_if ();
    bmsd_out_if out_if ();

    binary_mesh_stream_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (in_if.sink),
        .m_out       (out_if.source)
    );

    t_byte pending_bytes[$];
    t_rec  expected_recs[$];
    int    errors = 0;
    int    cycles = 0;
    int    bytes_made = 0;
    bit    in_fire = 0;
    int    idle_mode = 0;
    bit    hold_go = 0;
    int    hold_cnt = 0;
    bit    hold_done = 0;

    // decoder model state
    logic [1:0]  m_mode;
    logic [2:0]  m_phase;
    int          m_idx;
    logic [7:0]  m_buf [RecBytes];
    logic [31:0] m_vtot, m_ftot, m_ltot, m_done, m_second;
    logic [15:0] m_lods;
    logic [35:0] m_skip;
    logic        m_color;
    logic [31:0] m_lo [3];
    logic [31:0] m_hi [3];

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] rd16(int at);
        return {16'd0, m_buf[at + 1], m_buf[at]};
    endfunction

    function automatic logic [31:0] rd32(int at);
        return {m_buf[at + 3], m_buf[at + 2], m_buf[at + 1], m_buf[at]};
    endfunction

    // ieee single less-than on raw bits, nan never less, zeros equal
    function automatic bit float_below(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka, kb;
        if (a[30:0] > 31'h7F800000 || b[30:0] > 31'h7F800000) return 0;
        if (a[30:0] == 0 && b[30:0] == 0) return 0;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        return ka < kb;
    endfunction

    task automatic expect_rec(t_rec r);
        expected_recs.insert(expected_recs.size(), r);
    endtask

    task automatic start_body();
        m_phase = PH_HEADER;
        m_idx = 0;
        foreach (m_buf[i]) m_buf[i] = 8'd0;
        m_vtot = 0; m_ftot = 0; m_ltot = 0; m_done = 0;
        m_skip = 0; m_color = 0; m_second = 0; m_lods = 0;
        for (int i = 0; i < 3; i++) begin
            m_lo[i] = FLT_POS_MAX;
            m_hi[i] = FLT_NEG_MAX;
        end
    endtask

    task automatic read_header();
        if (m_mode == 2'd0) begin
            m_color = m_buf[2] == 8'd40;
            m_vtot = rd32(4); m_ftot = rd32(8); m_ltot = 0; m_skip = 0;
        end else if (m_mode == 2'd1) begin
            m_color = 1;
            m_ltot = rd16(6); m_vtot = rd32(8); m_ftot = rd32(12); m_skip = 0;
        end else begin
            m_color = 1;
            m_vtot = rd32(4); m_ftot = rd32(8); m_ltot = rd16(12);
            m_skip = rd16(14) != 0 ? {4'd0, m_vtot} * 36'd8 : 36'd0;
        end
    endtask

    // step into the current section, passing empty ones
    task automatic enter_section();
        m_done = 0;
        m_idx = 0;
        if (m_phase == PH_VERT && m_vtot == 0) m_phase = PH_SKIP;
        if (m_phase == PH_SKIP && m_skip == 0) m_phase = PH_FACE;
        if (m_phase == PH_FACE && m_ftot == 0) m_phase = PH_LOD;
        if (m_phase == PH_LOD && m_ltot == 0) m_phase = PH_FIN;
    endtask

    function automatic t_rec blank_rec(logic [2:0] kind, logic lastr);
        t_rec r;
        r = '0;
        r.record_kind = kind;
        r.last_record = lastr;
        return r;
    endfunction

    task automatic push_final();
        t_rec r;
        r = blank_rec(KIND_EMPTY, 1'b1);
        r.word0 = (m_lods > 1 && m_second < m_ftot) ? m_second : m_ftot;
        if (m_vtot != 0) begin
            r.record_kind = KIND_DONE;
            r.word1 = m_lo[0]; r.word2 = m_lo[1]; r.word3 = m_lo[2];
            r.word4 = m_hi[0]; r.word5 = m_hi[1]; r.word6 = m_hi[2];
            r.word7 = m_vtot;
        end
        expect_rec(r);
    endtask

    task automatic predict_byte(logic [7:0] b, logic lastb);
        t_rec r;
        logic [31:0] w [8];
        int len;
        bit ok;
        if (m_phase == PH_DRAIN) begin
            if (lastb) start_body();
            return;
        end
        if (m_phase == PH_SKIP) begin
            m_skip = m_skip - 1;
            if (m_skip == 0) begin
                m_phase = PH_FACE;
                enter_section();
            end
        end else begin
            if (m_idx < RecBytes) m_buf[m_idx] = b;
            m_idx++;
            if (m_phase == PH_HEADER) begin
                if (m_idx == 2 && rd16(0) != {16'd0, size_word(m_mode)}) begin
                    m_phase = PH_ERR;
                end else if (m_idx >= header_len(m_mode)) begin
                    read_header();
                    m_phase = PH_VERT;
                    enter_section();
                end
            end else if (m_phase == PH_VERT) begin
                len = (m_mode == 2'd0 && !m_color) ? 36 : 40;
                if (m_idx >= len) begin
                    for (int i = 0; i < 8; i++) w[i] = rd32(i * 4);
                    for (int i = 0; i < 3; i++) begin
                        if (float_below(w[i], m_lo[i])) m_lo[i] = w[i];
                        if (float_below(m_hi[i], w[i])) m_hi[i] = w[i];
                    end
                    r = blank_rec(KIND_VERT, 1'b0);
                    r.word0 = w[0]; r.word1 = w[1]; r.word2 = w[2]; r.word3 = w[3];
                    r.word4 = w[4]; r.word5 = w[5]; r.word6 = w[6]; r.word7 = w[7];
                    r.tangent_packed = {m_buf[34], m_buf[33], m_buf[32]};
                    r.color_rgba = m_color ? rd32(36) : 32'hFFFFFFFF;
                    expect_rec(r);
                    m_idx = 0;
                    m_done++;
                    if (m_done == m_vtot) begin
                        m_phase = PH_SKIP;
                        enter_section();
                    end
                end
            end else if (m_phase == PH_FACE) begin
                if (m_idx >= 12) begin
                    r = blank_rec(KIND_FACE, 1'b0);
                    r.word0 = rd32(0); r.word1 = rd32(4); r.word2 = rd32(8);
                    expect_rec(r);
                    m_idx = 0;
                    m_done++;
                    if (m_done == m_ftot) begin
                        m_phase = PH_LOD;
                        enter_section();
                    end
                end
            end else if (m_phase == PH_LOD) begin
                if (m_idx >= 4) begin
                    r = blank_rec(KIND_LOD, 1'b0);
                    r.word0 = rd32(0);
                    if (m_lods == 1) m_second = r.word0;
                    m_lods = m_lods + 1;
                    expect_rec(r);
                    m_idx = 0;
                    m_done++;
                    if (m_done == m_ltot) m_phase = PH_FIN;
                end
            end
        end
        if (m_phase == PH_FIN || m_phase == PH_ERR) begin
            if (m_phase == PH_FIN) push_final();
            else expect_rec(blank_rec(KIND_ERR, 1'b1));
            if (lastb) start_body();
            else m_phase = PH_DRAIN;
            return;
        end
        if (lastb) begin
            // body cut short: done only when nothing is still owed
            if (m_phase == PH_HEADER) begin
                ok = m_mode >= 2'd2 && m_idx >= size_word(m_mode);
                if (ok) begin
                    read_header();
                    ok = m_vtot == 0 && m_ftot == 0;
                end
            end else if (m_phase == PH_SKIP) begin
                ok = m_ftot == 0;
            end else begin
                ok = m_phase == PH_LOD;
            end
            if (ok) push_final();
            else expect_rec(blank_rec(KIND_ERR, 1'b1));
            start_body();
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %h actual %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor, checker and model, all on the rising edge
    always @(posedge i_clk) begin
        t_rec e;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAIL binary_mesh_stream_decoder");
            $finish;
        end else if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (expected_recs.size() == 0) begin
                    $error("record word with nothing expected, kind %0d", out_if.record_kind);
                    errors++;
                end else begin
                    e = expected_recs.pop_front();
                    check_field("record_kind", e.record_kind, out_if.record_kind);
                    check_field("word0", e.word0, out_if.word0);
                    check_field("word1", e.word1, out_if.word1);
                    check_field("word2", e.word2, out_if.word2);
                    check_field("word3", e.word3, out_if.word3);
                    check_field("word4", e.word4, out_if.word4);
                    check_field("word5", e.word5, out_if.word5);
                    check_field("word6", e.word6, out_if.word6);
                    check_field("word7", e.word7, out_if.word7);
                    check_field("tangent_packed", e.tangent_packed, out_if.tangent_packed);
                    check_field("color_rgba", e.color_rgba, out_if.color_rgba);
                    check_field("last_record", e.last_record, out_if.last_record);
                end
            end
            in_fire = in_if.valid && in_if.ready;
            if (in_fire) predict_byte(in_if.data_byte, in_if.last_byte);
            if (i_cfg_we) m_mode = i_cfg_wdata;
        end
    end

    // byte driver, changes on the falling edge
    always @(negedge i_clk) begin
        t_byte t;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_fire) begin
            // hold the offered word
        end else if (pending_bytes.size() != 0 &&
                     !((idle_mode == 1 || idle_mode == 3) &&
                       $urandom_range(99) < (idle_mode == 1 ? 53 : 14))) begin
            t = pending_bytes.pop_front();
            in_if.valid <= 1'b1;
            in_if.data_byte <= t.data;
            in_if.last_byte <= t.last;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_go && !hold_done && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            out_if.ready <= 1'b0;
            if (hold_cnt == 399) hold_done <= 1'b1;
        end else if (idle_mode == 2 || idle_mode == 3) begin
            out_if.ready <= $urandom_range(99) >= (idle_mode == 2 ? 53 : 14);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic add_byte(logic [7:0] b);
        t_byte t;
        t.data = b;
        t.last = 1'b0;
        pending_bytes.insert(pending_bytes.size(), t);
        bytes_made++;
    endtask

    task automatic add_word(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) add_byte(v[8 * i +: 8]);
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(9))
            0: return 32'h7FC00000 | $urandom_range(255);
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'h7F800000;
            4: return 32'hFF800000;
            5: return {1'($urandom_range(1)), 8'd127, 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // one mesh body; kind 0 well formed, 1 cut short, 2 bad size word,
    // 3 trailing bytes, 4 noise with random counts
    task automatic add_body(logic [1:0] mode, int kind, int vc, int fc, int lc, bit bones);
        int start;
        int cut;
        logic [7:0] stride;
        bit color;
        start = pending_bytes.size();
        stride = $urandom_range(2) == 0 ? 8'($urandom) : ($urandom_range(1) ? 8'd40 : 8'd36);
        color = mode != 2'd0 || stride == 8'd40;
        if (kind == 2) add_word(size_word(mode) ^ (16'd1 << $urandom_range(15)), 2);
        else add_word(size_word(mode), 2);
        if (kind == 4) begin
            for (int i = 2; i < header_len(mode) + $urandom_range(40); i++)
                add_byte(8'($urandom));
        end else if (mode == 2'd0) begin
            add_byte(stride); add_byte(8'($urandom));
            add_word(vc, 4); add_word(fc, 4);
        end else if (mode == 2'd1) begin
            add_word($urandom, 4); add_word(lc, 2); add_word(vc, 4); add_word(fc, 4);
        end else begin
            add_word($urandom, 2); add_word(vc, 4); add_word(fc, 4); add_word(lc, 2);
            add_word(bones ? 16'($urandom_range(1, 65535)) : 16'd0, 2);
            for (int i = 16; i < header_len(mode); i++) add_byte(8'($urandom));
        end
        if (kind != 4) begin
            for (int v = 0; v < vc; v++) begin
                for (int i = 0; i < 8; i++) add_word(pick_float(), 4);
                add_word($urandom, 4);
                if (color) add_word($urandom, 4);
            end
            if (bones && mode >= 2'd2) for (int i = 0; i < vc * 8; i++) add_byte(8'($urandom));
            for (int f = 0; f < fc * 3; f++)
                add_word($urandom_range(1) ? $urandom_range(7) : $urandom, 4);
            for (int l = 0; l < lc; l++)
                add_word($urandom_range(1) ? $urandom_range(4) : $urandom, 4);
            if (kind == 3) for (int i = 0; i < $urandom_range(1, 6); i++) add_byte(8'($urandom));
        end
        if (kind == 1 && pending_bytes.size() - start > 1) begin
            cut = $urandom_range(pending_bytes.size() - 1, start + 1);
            while (pending_bytes.size() > cut) begin
                void'(pending_bytes.pop_back());
                bytes_made--;
            end
        end
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endtask

    task automatic random_body(logic [1:0] mode);
        int r;
        int kind;
        r = $urandom_range(99);
        kind = r < 65 ? 0 : r < 78 ? 1 : r < 85 ? 2 : r < 93 ? 3 : 4;
        add_body(mode, kind, $urandom_range(3), $urandom_range(3),
                 mode == 2'd0 ? 0 : $urandom_range(3), $urandom_range(1));
    endtask

    // wait for the block to drain, then let its latency pass
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_if.valid || expected_recs.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 2'd0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'd0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        m_mode = 2'd0;
        start_body();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty mesh, bad size word, short bodies, full records
        write_mode(2'd0);
        add_body(2'd0, 0, 0, 0, 0, 0);
        add_body(2'd0, 2, 1, 1, 0, 0);
        add_body(2'd0, 0, 2, 1, 0, 0);
        add_body(2'd0, 1, 2, 2, 0, 0);
        add_body(2'd0, 3, 1, 0, 0, 0);
        wait_idle();
        write_mode(2'd3);
        add_body(2'd3, 0, 0, 0, 0, 1);
        add_body(2'd3, 0, 2, 0, 2, 1);
        add_body(2'd3, 0, 1, 3, 3, 0);
        wait_idle();
        write_mode(2'd1);
        add_body(2'd1, 0, 1, 1, 2, 0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            idle_mode = (p / 2) % 4;
            write_mode(2'(p));
            if (p == 1) hold_go = 1'b1;
            while (bytes_made < ByteTarget * (p + 1) / 8) random_body(2'(p));
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS binary_mesh_stream_decoder");
        end else begin
            $display("FAIL binary_mesh_stream_decoder");
        end
        $finish;
    end
endmodule
